// ===== sv/sss_pkg.sv =====
`timescale 1ns / 1ps
package sss_pkg;

  localparam int unsigned TmrW = 16;
  localparam int unsigned DivW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TICK_DIVISOR = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_C1_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_C1_LOW_TIME = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_C1_HIGH_TIME = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_C2_WAIT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SHAFT_DELAY = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SHAFT_LOW_TIME = 3'd6;

  // Reset values of the configuration registers
  localparam logic [DivW-1:0] RST_TICK_DIVISOR = 8'd4;
  localparam logic [TmrW-1:0] RST_C1_WAIT = 16'd114;
  localparam logic [TmrW-1:0] RST_C1_LOW_TIME = 16'd10;
  localparam logic [TmrW-1:0] RST_C1_HIGH_TIME = 16'd120;
  localparam logic [TmrW-1:0] RST_C2_WAIT = 16'd240;
  localparam logic [TmrW-1:0] RST_SHAFT_DELAY = 16'd100;
  localparam logic [TmrW-1:0] RST_SHAFT_LOW_TIME = 16'd1186;

  // Per-item control shared by the three sequencers
  typedef struct packed {
    logic adv;   // item moves from the input stage to the result register
    logic step;  // millisecond step on this item
    logic pwr;
    logic s1;
    logic s2;
  } step_ctrl_t;

  function automatic logic [TmrW-1:0] tmr_dec(input logic [TmrW-1:0] t, input logic step);
    if (step && (t != '0)) begin
      return t - TmrW'(1);
    end
    return t;
  endfunction

endpackage

// ===== sv/sss_in_if.sv =====
`timescale 1ns / 1ps
interface sss_in_if;
  logic valid;
  logic ready;
  logic power_level;
  logic solenoid1_level;
  logic solenoid2_level;
  logic tick;

  modport source (output valid, output power_level, output solenoid1_level,
                  output solenoid2_level, output tick, input ready);
  modport sink (input valid, input power_level, input solenoid1_level,
                input solenoid2_level, input tick, output ready);
endinterface

// ===== sv/sss_out_if.sv =====
`timescale 1ns / 1ps
interface sss_out_if;
  logic valid;
  logic ready;
  logic curtain1_level;
  logic curtain2_level;
  logic shaft_level;

  modport source (output valid, output curtain1_level, output curtain2_level,
                  output shaft_level, input ready);
  modport sink (input valid, input curtain1_level, input curtain2_level,
                input shaft_level, output ready);
endinterface

// ===== sv/sss_prescale.sv =====
`timescale 1ns / 1ps
module sss_prescale (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     tick,
  input  logic [sss_pkg::DivW-1:0] divisor,
  output logic                     step
);

  logic [sss_pkg::DivW-1:0] cnt_r;
  logic [sss_pkg::DivW-1:0] cnt_nxt;
  logic [sss_pkg::DivW:0]   cnt_inc;

  always_comb begin
    cnt_inc = {1'b0, cnt_r} + (sss_pkg::DivW+1)'(1);
    step    = 1'b0;
    cnt_nxt = cnt_r;
    if (tick) begin
      if (cnt_inc >= {1'b0, divisor}) begin
        step    = 1'b1;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_inc[sss_pkg::DivW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/sss_curtain1.sv =====
`timescale 1ns / 1ps
module sss_curtain1 (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sss_pkg::step_ctrl_t      ctrl,
  input  logic [sss_pkg::TmrW-1:0] wait_time,
  input  logic [sss_pkg::TmrW-1:0] low_time,
  input  logic [sss_pkg::TmrW-1:0] high_time,
  output logic                     line_nxt
);

  typedef enum logic [2:0] {
    PH_POWER, PH_SOL1, PH_SOL2, PH_WAIT, PH_LOW, PH_HIGH, PH_DOWN
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [sss_pkg::TmrW-1:0] tmr_r, tmr_nxt;
  logic                     line_r;

  always_comb begin
    phase_nxt = phase_r;
    tmr_nxt   = sss_pkg::tmr_dec(tmr_r, ctrl.step);
    line_nxt  = line_r;
    case (phase_r)
      PH_POWER: if (ctrl.pwr) begin
        line_nxt  = 1'b1;
        phase_nxt = PH_SOL1;
      end
      PH_SOL1: if (ctrl.s1) begin
        phase_nxt = PH_SOL2;
      end
      PH_SOL2: if (ctrl.s2) begin
        phase_nxt = PH_WAIT;
        tmr_nxt   = wait_time;
      end
      PH_WAIT: if (tmr_nxt == '0) begin
        line_nxt  = 1'b0;
        phase_nxt = PH_LOW;
        tmr_nxt   = low_time;
      end
      PH_LOW: if (tmr_nxt == '0) begin
        line_nxt  = 1'b1;
        phase_nxt = PH_HIGH;
        tmr_nxt   = high_time;
      end
      PH_HIGH: if (tmr_nxt == '0) begin
        line_nxt  = 1'b0;
        phase_nxt = PH_DOWN;
      end
      PH_DOWN: if (!ctrl.pwr) begin
        phase_nxt = PH_POWER;
      end
      default: phase_nxt = PH_POWER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_POWER;
      tmr_r   <= '0;
      line_r  <= 1'b0;
    end else if (ctrl.adv) begin
      phase_r <= phase_nxt;
      tmr_r   <= tmr_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// ===== sv/sss_curtain2.sv =====
`timescale 1ns / 1ps
module sss_curtain2 (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sss_pkg::step_ctrl_t      ctrl,
  input  logic [sss_pkg::TmrW-1:0] wait_time,
  output logic                     line_nxt
);

  typedef enum logic [1:0] {PH_POWER, PH_SOL2, PH_WAIT, PH_DOWN} phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [sss_pkg::TmrW-1:0] tmr_r, tmr_nxt;
  logic                     line_r;

  always_comb begin
    phase_nxt = phase_r;
    tmr_nxt   = sss_pkg::tmr_dec(tmr_r, ctrl.step);
    line_nxt  = line_r;
    case (phase_r)
      PH_POWER: if (ctrl.pwr) begin
        line_nxt  = 1'b1;
        phase_nxt = PH_SOL2;
      end
      PH_SOL2: if (ctrl.s2) begin
        phase_nxt = PH_WAIT;
        tmr_nxt   = wait_time;
      end
      PH_WAIT: if (tmr_nxt == '0) begin
        line_nxt  = 1'b0;
        phase_nxt = PH_DOWN;
      end
      default: if (!ctrl.pwr) begin
        phase_nxt = PH_POWER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_POWER;
      tmr_r   <= '0;
      line_r  <= 1'b0;
    end else if (ctrl.adv) begin
      phase_r <= phase_nxt;
      tmr_r   <= tmr_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// ===== sv/sss_shaft.sv =====
`timescale 1ns / 1ps
module sss_shaft (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sss_pkg::step_ctrl_t      ctrl,
  input  logic [sss_pkg::TmrW-1:0] delay_time,
  input  logic [sss_pkg::TmrW-1:0] low_time,
  output logic                     line_nxt
);

  typedef enum logic [1:0] {PH_POWER, PH_DELAY, PH_LOW, PH_DOWN} phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [sss_pkg::TmrW-1:0] tmr_r, tmr_nxt;
  logic                     line_r;

  always_comb begin
    phase_nxt = phase_r;
    tmr_nxt   = sss_pkg::tmr_dec(tmr_r, ctrl.step);
    line_nxt  = line_r;
    case (phase_r)
      PH_POWER: if (ctrl.pwr) begin
        phase_nxt = PH_DELAY;
        tmr_nxt   = delay_time;
      end
      PH_DELAY: if (tmr_nxt == '0) begin
        line_nxt  = 1'b0;
        phase_nxt = PH_LOW;
        tmr_nxt   = low_time;
      end
      PH_LOW: if (tmr_nxt == '0) begin
        line_nxt  = 1'b1;
        phase_nxt = PH_DOWN;
      end
      default: if (!ctrl.pwr) begin
        phase_nxt = PH_POWER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_POWER;
      tmr_r   <= '0;
      line_r  <= 1'b1;
    end else if (ctrl.adv) begin
      phase_r <= phase_nxt;
      tmr_r   <= tmr_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// ===== sv/shutter_signal_sequencer_top.sv =====
`timescale 1ns / 1ps
// Shutter signal sequencer. Each transfer on in_ch samples the power and
// solenoid levels and may carry a base tick; each yields exactly one transfer
// on out_ch with the driven curtain 1, curtain 2 and shaft levels after that
// item. Every tick_divisor-th tick (a divisor of 0 acts as 1) counts the
// three nonzero 16-bit timers down by one before the sequencers act. The
// block takes one item per clock cycle while the result side is not stalled;
// each item passes through the input register and the result register, with
// the prescaler and all three sequencer steps in the logic between them.
// Write configuration (cfg_we, cfg_idx, cfg_wdata) only while no item
// is in flight; indexes beyond the register list are ignored.
module shutter_signal_sequencer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  sss_in_if.sink                       in_ch,
  sss_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [sss_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [sss_pkg::CfgDataW-1:0] cfg_wdata
);

  // Configuration registers
  logic [sss_pkg::DivW-1:0] tick_div_r;
  logic [sss_pkg::TmrW-1:0] c1_wait_r, c1_low_r, c1_high_r;
  logic [sss_pkg::TmrW-1:0] c2_wait_r, sh_delay_r, sh_low_r;

  // Input stage
  logic in_vld_r;
  logic pwr_r, s1_r, s2_r, tick_r;

  // Result register
  logic out_vld_r;
  logic c1_r, c2_r, sh_r;

  logic                out_free;
  logic                adv;
  logic                step;
  logic                c1_nxt, c2_nxt, sh_nxt;
  sss_pkg::step_ctrl_t ctrl;

  // Advance the held item whenever the result register is empty or drains
  assign out_free    = !out_vld_r || out_ch.ready;
  assign adv         = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_div_r <= sss_pkg::RST_TICK_DIVISOR;
      c1_wait_r  <= sss_pkg::RST_C1_WAIT;
      c1_low_r   <= sss_pkg::RST_C1_LOW_TIME;
      c1_high_r  <= sss_pkg::RST_C1_HIGH_TIME;
      c2_wait_r  <= sss_pkg::RST_C2_WAIT;
      sh_delay_r <= sss_pkg::RST_SHAFT_DELAY;
      sh_low_r   <= sss_pkg::RST_SHAFT_LOW_TIME;
    end else if (cfg_we) begin
      case (cfg_idx)
        sss_pkg::REG_TICK_DIVISOR:   tick_div_r <= cfg_wdata[sss_pkg::DivW-1:0];
        sss_pkg::REG_C1_WAIT:        c1_wait_r  <= cfg_wdata;
        sss_pkg::REG_C1_LOW_TIME:    c1_low_r   <= cfg_wdata;
        sss_pkg::REG_C1_HIGH_TIME:   c1_high_r  <= cfg_wdata;
        sss_pkg::REG_C2_WAIT:        c2_wait_r  <= cfg_wdata;
        sss_pkg::REG_SHAFT_DELAY:    sh_delay_r <= cfg_wdata;
        sss_pkg::REG_SHAFT_LOW_TIME: sh_low_r   <= cfg_wdata;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Input register: capture on transfer, hold while the result side stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      pwr_r  <= in_ch.power_level;
      s1_r   <= in_ch.solenoid1_level;
      s2_r   <= in_ch.solenoid2_level;
      tick_r <= in_ch.tick;
    end
  end

  // Prescaler first, so the timers step before the sequencers look at them
  sss_prescale u_prescale (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .tick    (tick_r),
    .divisor (tick_div_r),
    .step    (step)
  );

  always_comb begin
    ctrl.adv  = adv;
    ctrl.step = step;
    ctrl.pwr  = pwr_r;
    ctrl.s1   = s1_r;
    ctrl.s2   = s2_r;
  end

  sss_curtain1 u_curtain1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .wait_time (c1_wait_r),
    .low_time  (c1_low_r),
    .high_time (c1_high_r),
    .line_nxt  (c1_nxt)
  );

  sss_curtain2 u_curtain2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .wait_time (c2_wait_r),
    .line_nxt  (c2_nxt)
  );

  // Shaft drives only its own line
  sss_shaft u_shaft (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .delay_time (sh_delay_r),
    .low_time   (sh_low_r),
    .line_nxt   (sh_nxt)
  );

  // Result register: load the new levels on advance, clear once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      sh_r <= sh_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.curtain1_level = c1_r;
  assign out_ch.curtain2_level = c2_r;
  assign out_ch.shaft_level    = sh_r;

  // An advanced item always reaches the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_ch.valid)
    else $error("advanced item did not reach the result register");

  // A held item is never dropped while the result side stalls
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r)
    else $error("input stage lost an item");

  // A result transfer with nothing behind it empties the result register
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !adv |=> !out_ch.valid)
    else $error("result repeated after transfer");

endmodule

// ===== tb/sv/shutter_line_scoreboard.sv =====
`timescale 1ns / 1ps
module shutter_line_scoreboard
  import sss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  sss_in_if                   in_mon,
  sss_out_if                  out_mon,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int unsigned         mismatches,
  output int unsigned         pending
);

  typedef enum logic [2:0] {
    C1_POWER, C1_SOL1, C1_SOL2, C1_WAIT, C1_LOW, C1_HIGH, C1_DOWN
  } c1_phase_e;
  typedef enum logic [1:0] {C2_POWER, C2_SOL2, C2_WAIT, C2_DOWN} c2_phase_e;
  typedef enum logic [1:0] {SH_POWER, SH_DELAY, SH_LOW, SH_DOWN} sh_phase_e;

  typedef struct packed {
    logic c1;
    logic c2;
    logic sh;
  } lines_t;

  // Settings as the block holds them
  logic [DivW-1:0] divisor;
  logic [TmrW-1:0] c1_wait, c1_low, c1_high, c2_wait, sh_delay, sh_low;

  // Sequencer state
  c1_phase_e       c1_ph;
  c2_phase_e       c2_ph;
  sh_phase_e       sh_ph;
  logic [TmrW-1:0] c1_tmr, c2_tmr, sh_tmr;
  logic [DivW-1:0] pre_cnt;
  lines_t          lines;

  lines_t      expected_lines[$];
  lines_t      want, got;
  int unsigned err_count = 0;

  assign mismatches = err_count;

  function automatic void reset_sequencers();
    divisor  = RST_TICK_DIVISOR;
    c1_wait  = RST_C1_WAIT;
    c1_low   = RST_C1_LOW_TIME;
    c1_high  = RST_C1_HIGH_TIME;
    c2_wait  = RST_C2_WAIT;
    sh_delay = RST_SHAFT_DELAY;
    sh_low   = RST_SHAFT_LOW_TIME;
    c1_ph    = C1_POWER;
    c2_ph    = C2_POWER;
    sh_ph    = SH_POWER;
    c1_tmr   = '0;
    c2_tmr   = '0;
    sh_tmr   = '0;
    pre_cnt  = '0;
    lines    = '{c1: 1'b0, c2: 1'b0, sh: 1'b1};
  endfunction

  function automatic void write_setting(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] data);
    case (idx)
      REG_TICK_DIVISOR:   divisor  = data[DivW-1:0];
      REG_C1_WAIT:        c1_wait  = data;
      REG_C1_LOW_TIME:    c1_low   = data;
      REG_C1_HIGH_TIME:   c1_high  = data;
      REG_C2_WAIT:        c2_wait  = data;
      REG_SHAFT_DELAY:    sh_delay = data;
      REG_SHAFT_LOW_TIME: sh_low   = data;
      default: ;
    endcase
  endfunction

  // Advance the prescaler, the timers and the three sequencers by one item
  function automatic lines_t step_lines(input logic pwr, input logic s1,
                                        input logic s2, input logic tk);
    logic [DivW:0] next_cnt;
    logic          ms_step;
    ms_step  = 1'b0;
    next_cnt = {1'b0, pre_cnt} + 1'b1;
    if (tk) begin
      if (next_cnt >= {1'b0, divisor}) begin
        pre_cnt = '0;
        ms_step = 1'b1;
      end else begin
        pre_cnt = next_cnt[DivW-1:0];
      end
    end
    if (ms_step) begin
      if (c1_tmr != '0) c1_tmr = c1_tmr - 1'b1;
      if (c2_tmr != '0) c2_tmr = c2_tmr - 1'b1;
      if (sh_tmr != '0) sh_tmr = sh_tmr - 1'b1;
    end

    case (c1_ph)
      C1_POWER: if (pwr) begin
        lines.c1 = 1'b1;
        c1_ph = C1_SOL1;
      end
      C1_SOL1: if (s1) c1_ph = C1_SOL2;
      C1_SOL2: if (s2) begin
        c1_ph = C1_WAIT;
        c1_tmr = c1_wait;
      end
      C1_WAIT: if (c1_tmr == '0) begin
        lines.c1 = 1'b0;
        c1_ph = C1_LOW;
        c1_tmr = c1_low;
      end
      C1_LOW: if (c1_tmr == '0) begin
        lines.c1 = 1'b1;
        c1_ph = C1_HIGH;
        c1_tmr = c1_high;
      end
      C1_HIGH: if (c1_tmr == '0) begin
        lines.c1 = 1'b0;
        c1_ph = C1_DOWN;
      end
      C1_DOWN: if (!pwr) c1_ph = C1_POWER;
      default: c1_ph = C1_POWER;
    endcase

    case (c2_ph)
      C2_POWER: if (pwr) begin
        lines.c2 = 1'b1;
        c2_ph = C2_SOL2;
      end
      C2_SOL2: if (s2) begin
        c2_ph = C2_WAIT;
        c2_tmr = c2_wait;
      end
      C2_WAIT: if (c2_tmr == '0) begin
        lines.c2 = 1'b0;
        c2_ph = C2_DOWN;
      end
      default: if (!pwr) c2_ph = C2_POWER;
    endcase

    case (sh_ph)
      SH_POWER: if (pwr) begin
        sh_ph = SH_DELAY;
        sh_tmr = sh_delay;
      end
      SH_DELAY: if (sh_tmr == '0) begin
        lines.sh = 1'b0;
        sh_ph = SH_LOW;
        sh_tmr = sh_low;
      end
      SH_LOW: if (sh_tmr == '0) begin
        lines.sh = 1'b1;
        sh_ph = SH_DOWN;
      end
      default: if (!pwr) sh_ph = SH_POWER;
    endcase
    return lines;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_sequencers();
      expected_lines.delete();
    end else begin
      if (cfg_we) write_setting(cfg_idx, cfg_wdata);
      if (in_mon.valid && in_mon.ready) begin
        expected_lines.push_back(step_lines(in_mon.power_level, in_mon.solenoid1_level,
                                            in_mon.solenoid2_level, in_mon.tick));
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{c1: out_mon.curtain1_level, c2: out_mon.curtain2_level,
                sh: out_mon.shaft_level};
        if (expected_lines.size() == 0) begin
          if (err_count < 10)
            $display("%0t: result with none expected: c1=%b c2=%b sh=%b",
                     $realtime, got.c1, got.c2, got.sh);
          err_count++;
        end else begin
          want = expected_lines.pop_front();
          if (got.c1 !== want.c1 || got.c2 !== want.c2 || got.sh !== want.sh) begin
            if (err_count < 10)
              $display("%0t: line mismatch: expected c1=%b c2=%b sh=%b, got c1=%b c2=%b sh=%b",
                       $realtime, want.c1, want.c2, want.sh, got.c1, got.c2, got.sh);
            err_count++;
          end
        end
      end
    end
    pending <= expected_lines.size();
  end

endmodule

// ===== tb/sv/shutter_signal_sequencer_top_tb.sv =====
`timescale 1ns / 1ps
module shutter_signal_sequencer_top_tb;
  import sss_pkg::*;

  // Generous ceiling: ~1900 items under the worst gaps and stalls, plus the
  // long receiver hold-offs and the idle waits.
  localparam int unsigned LIMIT_CYCLES = 250000;
  // Long receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES  = 300;
  // Index past the register list; the block must ignore writes to it
  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         mismatches;
  int unsigned         pending;
  int unsigned         cycle_count = 0;

  // Stimulus shaping shared between the sender and the receiver
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off
  bit no_idle  = 1'b0;  // last part of the run: both sides flat out
  bit gaps_on  = 1'b1;  // sender gaps allowed in the current stretch

  sss_in_if  in_ch();
  sss_out_if out_ch();

  shutter_signal_sequencer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Watches both channels and the register port, predicts the line levels
  // and compares every result transfer
  shutter_line_scoreboard line_sb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always #4 clk = ~clk;

  // Abort the run if it overstays the ceiling
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** shutter_signal_sequencer_top: FAILED **");
    $finish;
  end

  // Result side: mostly ready, with random stall bursts and, on request, one
  // long hold-off while the sender keeps offering. Each pass makes exactly
  // one assignment to ready and then waits for the clock.
  initial begin : result_sink
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until the transfer. An optional gap comes
  // first, so valid is lowered at most once in the step of the last transfer.
  task automatic send_item(input logic pwr, input logic s1, input logic s2,
                           input logic tk);
    if (!no_idle && gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.power_level     <= pwr;
    in_ch.solenoid1_level <= s1;
    in_ch.solenoid2_level <= s2;
    in_ch.tick            <= tk;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every expected result has arrived, then allow
  // for the pipeline to drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Load a full setting while the block is idle; the spare index gets noise
  task automatic apply_setting(input logic [DivW-1:0] div, input logic [TmrW-1:0] c1w,
                               input logic [TmrW-1:0] c1l, input logic [TmrW-1:0] c1h,
                               input logic [TmrW-1:0] c2w, input logic [TmrW-1:0] sd,
                               input logic [TmrW-1:0] sl);
    settle();
    write_reg(REG_TICK_DIVISOR, CfgDataW'(div));
    write_reg(REG_C1_WAIT, c1w);
    write_reg(REG_C1_LOW_TIME, c1l);
    write_reg(REG_C1_HIGH_TIME, c1h);
    write_reg(REG_C2_WAIT, c2w);
    write_reg(REG_SHAFT_DELAY, sd);
    write_reg(REG_SHAFT_LOW_TIME, sl);
    write_reg(REG_SPARE, CfgDataW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // One power cycle: power rises, solenoid 1 then solenoid 2 pulse, power
  // stays up with ticks at the given density, then falls to re-arm. A broken
  // episode is just random levels. Occasional glitches flip a level.
  task automatic run_episode(input bit well_formed, input int unsigned max_len,
                             input int unsigned tick_pct, inout int unsigned sent);
    int unsigned len, on_at, off_at, s1_at, s2_at;
    logic [2:0]  flip;
    logic [3:0]  noise;
    logic        p, a, b, t;
    len    = $urandom_range(12, max_len);
    on_at  = $urandom_range(0, 3);
    off_at = len - $urandom_range(1, 4);
    s1_at  = on_at + $urandom_range(0, 6);
    s2_at  = s1_at + $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      flip  = ($urandom_range(0, 31) == 0) ? 3'($urandom) : 3'b000;
      noise = 4'($urandom);
      p = well_formed ? (((i >= on_at) && (i < off_at)) ^ flip[2]) : noise[3];
      a = well_formed ? (((i >= s1_at) && (i < s1_at + 3)) ^ flip[1]) : noise[2];
      b = well_formed ? (((i >= s2_at) && (i < s2_at + 3)) ^ flip[0]) : noise[1];
      t = well_formed ? ($urandom_range(0, 99) < tick_pct) : noise[0];
      send_item(p, a, b, t);
      sent++;
    end
  endtask

  // Run episodes until the phase's share of items is through; about one in
  // five is broken, and sender gaps come and go between episodes
  task automatic run_phase(input int unsigned quota, input int unsigned max_len,
                           input int unsigned tick_pct);
    int unsigned sent;
    sent = 0;
    while (sent < quota) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      run_episode(($urandom_range(0, 4) != 0), max_len, tick_pct, sent);
    end
  endtask

  initial begin : stimulus
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.power_level     <= 1'b0;
    in_ch.solenoid1_level <= 1'b0;
    in_ch.solenoid2_level <= 1'b0;
    in_ch.tick            <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= REG_TICK_DIVISOR;
    cfg_wdata             <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every combination of the four input bits under the reset
    // setting, power low first so the sequencers arm on the second half,
    // then a run of ticks with power held
    for (int c = 0; c < 16; c++) send_item(c[3], c[2], c[1], c[0]);
    for (int c = 0; c < 6; c++) send_item(1'b1, 1'b0, 1'b1, 1'b1);

    // Fast steps with short timers; back the block up once
    apply_setting(8'd1, 16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                  16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                  16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)));
    hold_req = 1'b1;
    run_phase(260, 60, 70);

    // All zero: divisor zero steps on every tick, zero durations expire at once
    apply_setting(8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(240, 40, 50);

    // Slower prescaler with longer timers and long powered stretches
    apply_setting(8'd2, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                  16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                  16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
    run_phase(280, 120, 80);

    // Top of every range: timers never run out within the phase
    apply_setting(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    hold_req = 1'b1;
    run_phase(150, 60, 90);

    // Short nonzero timers with dense ticks, so most sequences complete
    apply_setting(8'd1, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
    run_phase(280, 50, 90);

    apply_setting(8'($urandom_range(1, 3)), 16'($urandom_range(0, 30)),
                  16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                  16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                  16'($urandom_range(0, 30)));
    run_phase(270, 80, 70);

    // Last stretch: no idling on either side
    no_idle = 1'b1;
    apply_setting(8'd1, 16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
                  16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
                  16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)));
    run_phase(260, 60, 75);

    // Drain every outstanding result, then give the verdict
    settle();
    if (mismatches == 0) begin
      $display("** shutter_signal_sequencer_top: PASSED **");
    end else begin
      $display("** shutter_signal_sequencer_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sss_pkg.sv
sv/sss_in_if.sv
sv/sss_out_if.sv
sv/sss_prescale.sv
sv/sss_curtain1.sv
sv/sss_curtain2.sv
sv/sss_shaft.sv
sv/shutter_signal_sequencer_top.sv
tb/sv/shutter_line_scoreboard.sv
tb/sv/shutter_signal_sequencer_top_tb.sv
